// ===== sv/lau_pkg.sv =====
package lau_pkg;

  // Fixed-point format of vectors and the word widths of the ports
  localparam int FRAC_BITS = 12;
  localparam int IN_W      = 24;
  localparam int RANGE_W   = 23;
  localparam int COS_W     = 16;
  localparam int TYPE_W    = 2;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int GAIN_W    = 30;
  localparam int CONE_W    = 17;

  // Derived datapath widths
  localparam int D2_W   = 2 * IN_W;            // sum of three squares
  localparam int ROOT_W = IN_W;                // integer square root
  localparam int DOT_W  = 2 * IN_W + 2;        // signed dot product
  localparam int RR_W   = 2 * RANGE_W;

  // Distance falloff constants
  localparam int MIN_DIST  = ((1 << FRAC_BITS) + 50) / 100;
  localparam int SHORT_THR = (1 << (2 * FRAC_BITS)) / 10000;
  localparam int VEC_ONE   = 1 << FRAC_BITS;
  localparam int INV_EXP   = 16 + 2 * FRAC_BITS;
  localparam int INV_NUM_W = INV_EXP + 1;
  localparam int INV_QW    = INV_EXP - $clog2(MIN_DIST * MIN_DIST) + 1;
  localparam int DB_NUM_W  = INV_QW + RANGE_W;

  // Cone constants
  localparam int COS_FRAC   = 15;
  localparam int COS_QW     = 17;
  localparam int COS_ONE    = 1 << COS_FRAC;
  localparam int CNUM_W     = DOT_W - 1 + COS_FRAC;
  localparam int C_W        = COS_W + 2;
  localparam int SPAN_W     = COS_W + 1;
  localparam int BLEND_FRAC = 16;
  localparam int BLEND_QW   = 17;
  localparam int DNUM_W     = SPAN_W + BLEND_FRAC;

  localparam int GAIN_ONE = 65536;

  // Light types
  localparam logic [TYPE_W-1:0] LT_DIR   = 2'd0;
  localparam logic [TYPE_W-1:0] LT_POINT = 2'd1;
  localparam logic [TYPE_W-1:0] LT_SPOT  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TYPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 3'd6;

  // Register reset values
  localparam logic [TYPE_W-1:0]       RST_TYPE  = LT_POINT;
  localparam logic [RANGE_W-1:0]      RST_RANGE = 23'd40960;
  localparam logic signed [COS_W-1:0] RST_INNER = 16'sd31651;
  localparam logic signed [COS_W-1:0] RST_OUTER = 16'sd30274;
  localparam logic signed [IN_W-1:0]  RST_DIR_X = 24'sd0;
  localparam logic signed [IN_W-1:0]  RST_DIR_Y = -24'sd4096;
  localparam logic signed [IN_W-1:0]  RST_DIR_Z = 24'sd0;

  // Pipeline lengths; the cone path is padded to meet the distance path
  localparam int CONE_DLY = 2 * INV_QW + 1 - (COS_QW + BLEND_QW + 2);

endpackage

// ===== sv/light_attenuation_unit_core.sv =====
// Light attenuation core: distance falloff, range test and spot-cone gain
// for one light, one offset word (light to point, signed Q12.12) per item.
// Input: start with in_off_x/y/z; busy is never raised, so a word may be
// started in every cycle.
// Output: out_valid marks out_distance_gain (Q14.16), out_cone_gain (Q1.16)
// and out_in_range for one cycle. The receiver cannot hold results off and
// the pipeline never stalls.
// Throughput: one word per cycle. The depth is set by the 24-step
// square-root pipeline and two 30-step restoring dividers (inverse square,
// then the range ratio); the cone path (two 17-step dividers) is delayed
// to line up with them.
// Configuration: cfg_we, cfg_index, cfg_data write one register per edge;
// write only while no word is in flight.
// Reset (rst_n low, synchronous) clears all valid bits and loads the
// register defaults: point light, range 10.0, cone cosines for 15 and 22.5
// degree half angles, direction pointing down.
module light_attenuation_unit_core
  import lau_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [IN_W-1:0]    in_off_x,
  input  logic signed [IN_W-1:0]    in_off_y,
  input  logic signed [IN_W-1:0]    in_off_z,
  output logic                      out_valid,
  output logic [GAIN_W-1:0]         out_distance_gain,
  output logic [CONE_W-1:0]         out_cone_gain,
  output logic                      out_in_range,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  typedef struct packed {
    logic in_range;
    logic dist_zero;
  } dist_flag_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic                    lo_short;
    logic                    ld_short;
    dist_flag_t              fl;
  } sq_side_t;

  typedef struct packed {
    logic [RANGE_W-1:0] rmd;
    dist_flag_t         fl;
  } dist_side_t;

  typedef struct packed {
    logic one;
    logic zero;
  } cone_flag_t;

  // ---------------------------------------------------------------- config
  logic [TYPE_W-1:0]       type_r;
  logic [RANGE_W-1:0]      range_r;
  logic signed [COS_W-1:0] inner_r;
  logic signed [COS_W-1:0] outer_r;
  logic signed [IN_W-1:0]  dir_x_r;
  logic signed [IN_W-1:0]  dir_y_r;
  logic signed [IN_W-1:0]  dir_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r  <= RST_TYPE;
      range_r <= RST_RANGE;
      inner_r <= RST_INNER;
      outer_r <= RST_OUTER;
      dir_x_r <= RST_DIR_X;
      dir_y_r <= RST_DIR_Y;
      dir_z_r <= RST_DIR_Z;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TYPE:  type_r  <= cfg_data[TYPE_W-1:0];
        REG_RANGE: range_r <= cfg_data[RANGE_W-1:0];
        REG_INNER: inner_r <= cfg_data[COS_W-1:0];
        REG_OUTER: outer_r <= cfg_data[COS_W-1:0];
        REG_DIR_X: dir_x_r <= cfg_data[IN_W-1:0];
        REG_DIR_Y: dir_y_r <= cfg_data[IN_W-1:0];
        REG_DIR_Z: dir_z_r <= cfg_data[IN_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // ------------------------------------------------------- stage 1: products
  logic                    s1_vld_r;
  logic signed [D2_W-1:0]  s1_sqx_r, s1_sqy_r, s1_sqz_r;
  logic signed [D2_W-1:0]  s1_sdx_r, s1_sdy_r, s1_sdz_r;
  logic signed [D2_W-1:0]  s1_dpx_r, s1_dpy_r, s1_dpz_r;
  logic [RR_W-1:0]         s1_rr_r;
  logic signed [IN_W-1:0]  s1_offy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_sqx_r  <= in_off_x * in_off_x;
    s1_sqy_r  <= in_off_y * in_off_y;
    s1_sqz_r  <= in_off_z * in_off_z;
    s1_sdx_r  <= dir_x_r * dir_x_r;
    s1_sdy_r  <= dir_y_r * dir_y_r;
    s1_sdz_r  <= dir_z_r * dir_z_r;
    s1_dpx_r  <= dir_x_r * in_off_x;
    s1_dpy_r  <= dir_y_r * in_off_y;
    s1_dpz_r  <= dir_z_r * in_off_z;
    s1_rr_r   <= range_r * range_r;
    s1_offy_r <= in_off_y;
  end

  // ------------------------------------ stage 2: sums, short-vector fallback
  logic [D2_W-1:0]         c2_d2, c2_ld2;
  logic                    c2_lo_short, c2_ld_short;
  logic signed [DOT_W-1:0] c2_dot;
  logic [D2_W-1:0]         c2_rr;

  always_comb begin
    c2_d2  = $unsigned(s1_sqx_r) + $unsigned(s1_sqy_r) + $unsigned(s1_sqz_r);
    c2_ld2 = $unsigned(s1_sdx_r) + $unsigned(s1_sdy_r) + $unsigned(s1_sdz_r);
    c2_rr  = D2_W'(s1_rr_r);
    c2_lo_short = c2_d2 <= D2_W'(SHORT_THR);
    c2_ld_short = c2_ld2 <= D2_W'(SHORT_THR);
    // short direction is (0,-1,0), short offset is (0,1,0)
    priority if (c2_lo_short && c2_ld_short) begin
      c2_dot = -(DOT_W'(VEC_ONE) <<< FRAC_BITS);
    end else if (c2_lo_short) begin
      c2_dot = DOT_W'(dir_y_r) <<< FRAC_BITS;
    end else if (c2_ld_short) begin
      c2_dot = -(DOT_W'(s1_offy_r) <<< FRAC_BITS);
    end else begin
      c2_dot = DOT_W'(s1_dpx_r) + DOT_W'(s1_dpy_r) + DOT_W'(s1_dpz_r);
    end
  end

  // --------------------------------------- square roots, one bit per stage
  logic            sq_vld_r  [0:ROOT_W];
  sq_side_t        sq_side_r [0:ROOT_W];
  logic [D2_W-1:0] sqo_x_r   [0:ROOT_W];
  logic [D2_W:0]   sqo_r_r   [0:ROOT_W];
  logic [D2_W-1:0] sqd_x_r   [0:ROOT_W];
  logic [D2_W:0]   sqd_r_r   [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else begin
      sq_vld_r[0] <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sqo_x_r[0] <= c2_d2;
    sqo_r_r[0] <= '0;
    sqd_x_r[0] <= c2_ld2;
    sqd_r_r[0] <= '0;
    sq_side_r[0].dot          <= c2_dot;
    sq_side_r[0].lo_short     <= c2_lo_short;
    sq_side_r[0].ld_short     <= c2_ld_short;
    sq_side_r[0].fl.in_range  <= c2_d2 <= c2_rr;
    sq_side_r[0].fl.dist_zero <= c2_d2 >= c2_rr;
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    localparam logic [D2_W:0] SQ_BIT = (D2_W+1)'(1) << (2 * (ROOT_W - 1 - k));
    logic [D2_W:0] o_sum, d_sum;
    logic          o_ge, d_ge;

    always_comb begin
      o_sum = sqo_r_r[k] + SQ_BIT;
      d_sum = sqd_r_r[k] + SQ_BIT;
      o_ge  = {1'b0, sqo_x_r[k]} >= o_sum;
      d_ge  = {1'b0, sqd_x_r[k]} >= d_sum;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k+1] <= 1'b0;
      end else begin
        sq_vld_r[k+1] <= sq_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      sq_side_r[k+1] <= sq_side_r[k];
      if (o_ge) begin
        sqo_x_r[k+1] <= sqo_x_r[k] - o_sum[D2_W-1:0];
        sqo_r_r[k+1] <= (sqo_r_r[k] >> 1) + SQ_BIT;
      end else begin
        sqo_x_r[k+1] <= sqo_x_r[k];
        sqo_r_r[k+1] <= sqo_r_r[k] >> 1;
      end
      if (d_ge) begin
        sqd_x_r[k+1] <= sqd_x_r[k] - d_sum[D2_W-1:0];
        sqd_r_r[k+1] <= (sqd_r_r[k] >> 1) + SQ_BIT;
      end else begin
        sqd_x_r[k+1] <= sqd_x_r[k];
        sqd_r_r[k+1] <= sqd_r_r[k] >> 1;
      end
    end
  end

  // ------------------- stage 3: e^2, length product, divider numerators
  logic [ROOT_W-1:0]       c3_d, c3_ld, c3_lo, c3_e;
  logic signed [DOT_W-1:0] c3_neg, c3_mag;
  sq_side_t                c3_side;

  always_comb begin
    c3_side = sq_side_r[ROOT_W];
    c3_d    = sqo_r_r[ROOT_W][ROOT_W-1:0];
    c3_ld   = c3_side.ld_short ? ROOT_W'(VEC_ONE) : sqd_r_r[ROOT_W][ROOT_W-1:0];
    c3_lo   = c3_side.lo_short ? ROOT_W'(VEC_ONE) : c3_d;
    c3_e    = (c3_d > ROOT_W'(MIN_DIST)) ? c3_d : ROOT_W'(MIN_DIST);
    c3_neg  = -c3_side.dot;
    c3_mag  = c3_side.dot[DOT_W-1] ? c3_neg : c3_side.dot;
  end

  // inverse square: 2^INV_EXP / e^2
  logic                 dva_vld_r  [0:INV_QW];
  dist_side_t           dva_side_r [0:INV_QW];
  logic [INV_NUM_W-1:0] dva_rem_r  [0:INV_QW];
  logic [INV_QW-1:0]    dva_q_r    [0:INV_QW];
  logic [D2_W-1:0]      dva_div_r  [0:INV_QW];

  // cosine: |dot| * 2^15 / (|dir| * |off|)
  logic [CNUM_W-1:0]    dvc_rem_r  [0:COS_QW];
  logic [COS_QW-1:0]    dvc_q_r    [0:COS_QW];
  logic [D2_W-1:0]      dvc_div_r  [0:COS_QW];
  logic                 dvc_neg_r  [0:COS_QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dva_vld_r[0] <= 1'b0;
    end else begin
      dva_vld_r[0] <= sq_vld_r[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    dva_rem_r[0]      <= INV_NUM_W'(1) << INV_EXP;
    dva_q_r[0]        <= '0;
    dva_div_r[0]      <= c3_e * c3_e;
    dva_side_r[0].rmd <= range_r - c3_d[RANGE_W-1:0];
    dva_side_r[0].fl  <= c3_side.fl;
    dvc_rem_r[0]      <= CNUM_W'(c3_mag[DOT_W-2:0]) << COS_FRAC;
    dvc_q_r[0]        <= '0;
    dvc_div_r[0]      <= c3_ld * c3_lo;
    dvc_neg_r[0]      <= c3_side.dot[DOT_W-1];
  end

  localparam int DA_CMP_W = D2_W + INV_QW;

  for (genvar k = 0; k < INV_QW; k++) begin : g_div_inv
    localparam int SH = INV_QW - 1 - k;
    logic [DA_CMP_W-1:0] sub;
    logic                ge;

    always_comb begin
      sub = DA_CMP_W'(dva_div_r[k]) << SH;
      ge  = DA_CMP_W'(dva_rem_r[k]) >= sub;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dva_vld_r[k+1] <= 1'b0;
      end else begin
        dva_vld_r[k+1] <= dva_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      dva_side_r[k+1] <= dva_side_r[k];
      dva_div_r[k+1]  <= dva_div_r[k];
      dva_q_r[k+1]    <= {dva_q_r[k][INV_QW-2:0], ge};
      dva_rem_r[k+1]  <= ge ? dva_rem_r[k] - sub[INV_NUM_W-1:0] : dva_rem_r[k];
    end
  end

  // ---------------- range ratio: inv * (range - d) / range
  logic                dvb_vld_r [0:INV_QW];
  dist_flag_t          dvb_fl_r  [0:INV_QW];
  logic [DB_NUM_W-1:0] dvb_rem_r [0:INV_QW];
  logic [INV_QW-1:0]   dvb_q_r   [0:INV_QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvb_vld_r[0] <= 1'b0;
    end else begin
      dvb_vld_r[0] <= dva_vld_r[INV_QW];
    end
  end

  always_ff @(posedge clk) begin
    dvb_rem_r[0] <= dva_q_r[INV_QW] * dva_side_r[INV_QW].rmd;
    dvb_q_r[0]   <= '0;
    dvb_fl_r[0]  <= dva_side_r[INV_QW].fl;
  end

  localparam int DB_CMP_W = DB_NUM_W + 1;

  for (genvar k = 0; k < INV_QW; k++) begin : g_div_rng
    localparam int SH = INV_QW - 1 - k;
    logic [DB_CMP_W-1:0] sub;
    logic                ge;

    always_comb begin
      sub = DB_CMP_W'(range_r) << SH;
      ge  = DB_CMP_W'(dvb_rem_r[k]) >= sub;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dvb_vld_r[k+1] <= 1'b0;
      end else begin
        dvb_vld_r[k+1] <= dvb_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      dvb_fl_r[k+1]  <= dvb_fl_r[k];
      dvb_q_r[k+1]   <= {dvb_q_r[k][INV_QW-2:0], ge};
      dvb_rem_r[k+1] <= ge ? dvb_rem_r[k] - sub[DB_NUM_W-1:0] : dvb_rem_r[k];
    end
  end

  // ----------------------------------------------------- cosine divider
  localparam int DC_CMP_W = D2_W + COS_QW;

  for (genvar k = 0; k < COS_QW; k++) begin : g_div_cos
    localparam int SH = COS_QW - 1 - k;
    logic [DC_CMP_W-1:0] sub;
    logic                ge;

    always_comb begin
      sub = DC_CMP_W'(dvc_div_r[k]) << SH;
      ge  = DC_CMP_W'(dvc_rem_r[k]) >= sub;
    end

    always_ff @(posedge clk) begin
      dvc_div_r[k+1] <= dvc_div_r[k];
      dvc_neg_r[k+1] <= dvc_neg_r[k];
      dvc_q_r[k+1]   <= {dvc_q_r[k][COS_QW-2:0], ge};
      dvc_rem_r[k+1] <= ge ? dvc_rem_r[k] - sub[CNUM_W-1:0] : dvc_rem_r[k];
    end
  end

  // ------------------------ clamp cosine, compare with the cone limits
  logic [COS_QW-1:0]       c5_mag;
  logic signed [C_W-1:0]   c5_cos, c5_inner, c5_outer, c5_diff;
  logic signed [SPAN_W-1:0] span;

  always_comb begin
    c5_mag   = (dvc_q_r[COS_QW] > COS_QW'(COS_ONE)) ? COS_QW'(COS_ONE) : dvc_q_r[COS_QW];
    c5_cos   = dvc_neg_r[COS_QW] ? -C_W'(c5_mag) : C_W'(c5_mag);
    c5_inner = C_W'(inner_r);
    c5_outer = C_W'(outer_r);
    c5_diff  = c5_cos - c5_outer;
    // only used inside the blend band, where inner is above outer
    span     = SPAN_W'(inner_r) - SPAN_W'(outer_r);
  end

  logic [DNUM_W-1:0]   dvd_rem_r [0:BLEND_QW];
  logic [BLEND_QW-1:0] dvd_q_r   [0:BLEND_QW];
  cone_flag_t          dvd_fl_r  [0:BLEND_QW];

  always_ff @(posedge clk) begin
    dvd_rem_r[0]     <= DNUM_W'(c5_diff[SPAN_W-1:0]) << BLEND_FRAC;
    dvd_q_r[0]       <= '0;
    dvd_fl_r[0].one  <= c5_cos > c5_inner;
    dvd_fl_r[0].zero <= c5_cos <= c5_outer;
  end

  localparam int DD_CMP_W = DNUM_W + 1;

  for (genvar k = 0; k < BLEND_QW; k++) begin : g_div_blend
    localparam int SH = BLEND_QW - 1 - k;
    logic [DD_CMP_W-1:0] sub;
    logic                ge;

    always_comb begin
      sub = DD_CMP_W'($unsigned(span)) << SH;
      ge  = DD_CMP_W'(dvd_rem_r[k]) >= sub;
    end

    always_ff @(posedge clk) begin
      dvd_fl_r[k+1]  <= dvd_fl_r[k];
      dvd_q_r[k+1]   <= {dvd_q_r[k][BLEND_QW-2:0], ge};
      dvd_rem_r[k+1] <= ge ? dvd_rem_r[k] - sub[DNUM_W-1:0] : dvd_rem_r[k];
    end
  end

  // ------------------------- squared blend, then delay to meet the distance
  logic [2*BLEND_QW-1:0] c6_sq;
  logic [CONE_W-1:0]     c6_gain;
  logic [CONE_W-1:0]     cdl_r [0:CONE_DLY];

  always_comb begin
    c6_sq = dvd_q_r[BLEND_QW] * dvd_q_r[BLEND_QW];
    priority if (dvd_fl_r[BLEND_QW].one) begin
      c6_gain = CONE_W'(GAIN_ONE);
    end else if (dvd_fl_r[BLEND_QW].zero) begin
      c6_gain = '0;
    end else begin
      c6_gain = c6_sq[BLEND_FRAC+CONE_W-1:BLEND_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    cdl_r[0] <= c6_gain;
  end

  for (genvar k = 0; k < CONE_DLY; k++) begin : g_cone_dly
    always_ff @(posedge clk) begin
      cdl_r[k+1] <= cdl_r[k];
    end
  end

  // ------------------------------------------------------------ output word
  logic              out_valid_r;
  logic [GAIN_W-1:0] out_dist_r;
  logic [CONE_W-1:0] out_cone_r;
  logic              out_in_range_r;
  logic [GAIN_W-1:0] dist_gain;

  assign dist_gain = dvb_fl_r[INV_QW].dist_zero ? '0 : GAIN_W'(dvb_q_r[INV_QW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dvb_vld_r[INV_QW];
    end
  end

  always_ff @(posedge clk) begin
    unique case (type_r)
      LT_DIR: begin
        out_dist_r     <= GAIN_W'(GAIN_ONE);
        out_cone_r     <= CONE_W'(GAIN_ONE);
        out_in_range_r <= 1'b1;
      end
      LT_SPOT: begin
        out_dist_r     <= dist_gain;
        out_cone_r     <= cdl_r[CONE_DLY];
        out_in_range_r <= dvb_fl_r[INV_QW].in_range;
      end
      default: begin
        // point light, and the unused type code
        out_dist_r     <= dist_gain;
        out_cone_r     <= CONE_W'(GAIN_ONE);
        out_in_range_r <= dvb_fl_r[INV_QW].in_range;
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_distance_gain = out_dist_r;
  assign out_cone_gain     = out_cone_r;
  assign out_in_range      = out_in_range_r;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import lau_pkg::*;

  localparam int LATENCY   = 89;
  localparam int CYC_LIMIT = 900000;
  localparam int N_RANDOM  = 1630;

  // type code with no name of its own in the block; acts as a point light
  localparam logic [TYPE_W-1:0] LT_SPARE = 2'd3;

  typedef struct packed {
    logic [GAIN_W-1:0] dist_gain;
    logic [CONE_W-1:0] cone_gain;
    logic              in_range;
  } atten_t;

  typedef struct {
    logic [IN_W-1:0] ox, oy, oz;
    logic            has_exp;
    atten_t          exp_res;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [IN_W-1:0] in_off_x = '0, in_off_y = '0, in_off_z = '0;
  logic out_valid;
  logic [GAIN_W-1:0] out_distance_gain;
  logic [CONE_W-1:0] out_cone_gain;
  logic out_in_range;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  light_attenuation_unit_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the light registers
  logic [1:0] lt_type;
  longint unsigned lt_range;
  longint lt_inner, lt_outer;
  longint lt_dir[3];

  atten_t pending_q[$];
  int errors = 0;
  int n_words = 0;
  int n_results = 0;
  int n_spot = 0;
  longint unsigned cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("light_attenuation_unit_core verification failed");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
  endtask

  always @(posedge clk) begin
    atten_t e;
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_q.size() == 0) begin
        report("unexpected word", out_distance_gain, 0);
      end else begin
        e = pending_q.pop_front();
        if (out_distance_gain !== e.dist_gain)
          report("distance_gain", out_distance_gain, e.dist_gain);
        if (out_cone_gain !== e.cone_gain) report("cone_gain", out_cone_gain, e.cone_gain);
        if (out_in_range !== e.in_range) report("in_range", out_in_range, e.in_range);
      end
    end
  end

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic atten_t attenuate(input logic [IN_W-1:0] ox, oy, oz);
    atten_t res;
    longint o[3], dv[3], pv[3], dot, c;
    longint unsigned d2, rr, d, e, inv, g, ld2, mag, den, f;
    longint unsigned thr = (64'd1 << (2 * FRAC_BITS)) / 10000;
    o[0] = longint'(signed'(ox));
    o[1] = longint'(signed'(oy));
    o[2] = longint'(signed'(oz));
    if (lt_type == LT_DIR) begin
      res.dist_gain = GAIN_ONE;
      res.cone_gain = GAIN_ONE;
      res.in_range = 1'b1;
      return res;
    end
    d2 = o[0] * o[0] + o[1] * o[1] + o[2] * o[2];
    rr = lt_range * lt_range;
    res.in_range = d2 <= rr;
    if (d2 >= rr) begin
      g = 0;
    end else begin
      d = int_sqrt(d2);
      e = d > MIN_DIST ? d : MIN_DIST;
      inv = (64'd1 << INV_EXP) / (e * e);
      g = inv * (lt_range - d) / lt_range;
      if (g > 64'h3FFF_FFFF) g = 64'h3FFF_FFFF;
    end
    res.dist_gain = g[GAIN_W-1:0];
    res.cone_gain = GAIN_ONE;
    if (lt_type == LT_SPOT) begin
      dv = lt_dir;
      pv = o;
      ld2 = dv[0] * dv[0] + dv[1] * dv[1] + dv[2] * dv[2];
      if (ld2 <= thr) begin
        dv = '{0, -VEC_ONE, 0};
        ld2 = 64'd1 << (2 * FRAC_BITS);
      end
      if (d2 <= thr) begin
        pv = '{0, VEC_ONE, 0};
        d2 = 64'd1 << (2 * FRAC_BITS);
      end
      dot = dv[0] * pv[0] + dv[1] * pv[1] + dv[2] * pv[2];
      den = int_sqrt(ld2) * int_sqrt(d2);
      if (den == 0) den = 1;
      mag = dot < 0 ? -dot : dot;
      mag = (mag << 15) / den;
      if (mag > 32768) mag = 32768;
      c = dot < 0 ? -longint'(mag) : longint'(mag);
      if (c > lt_inner) begin
        res.cone_gain = GAIN_ONE;
      end else if (c <= lt_outer) begin
        res.cone_gain = 0;
      end else begin
        f = (unsigned'(c - lt_outer) << 16) / unsigned'(lt_inner - lt_outer);
        f = (f * f) >> 16;
        res.cone_gain = f[CONE_W-1:0];
      end
    end
    return res;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint val);
    logic [CFG_W-1:0] v = val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    case (idx)
      REG_TYPE:  lt_type = v[1:0];
      REG_RANGE: lt_range = v[RANGE_W-1:0];
      REG_INNER: lt_inner = longint'(signed'(v[COS_W-1:0]));
      REG_OUTER: lt_outer = longint'(signed'(v[COS_W-1:0]));
      REG_DIR_X: lt_dir[0] = longint'(signed'(v));
      REG_DIR_Y: lt_dir[1] = longint'(signed'(v));
      REG_DIR_Z: lt_dir[2] = longint'(signed'(v));
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // caller is at a posedge with start possibly high
  task automatic send_word(input logic [IN_W-1:0] ox, oy, oz, input int gap,
                           input logic has_exp = 1'b0, input atten_t want = '{0, 0, 0});
    atten_t p;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_off_x <= ox;
    in_off_y <= oy;
    in_off_z <= oz;
    do @(posedge clk); while (busy);
    p = attenuate(ox, oy, oz);
    if (has_exp && p != want) report("predictor vs table", p.dist_gain, want.dist_gain);
    pending_q.push_back(has_exp ? want : p);
    n_words++;
    if (lt_type == LT_SPOT) n_spot++;
  endtask

  function automatic logic [IN_W-1:0] rnd_comp(input int mode);
    case (mode)
      0: return $urandom_range(0, 2 * VEC_ONE) - VEC_ONE;
      1: return $urandom_range(0, 24 * VEC_ONE) - 12 * VEC_ONE;
      2: return $urandom;
      default: return $urandom_range(0, 80) - 40;
    endcase
  endfunction

  vec_row_t dir_rows[] = '{
    '{24'sd0, 24'sd0, 24'sd0, 1'b1, '{GAIN_ONE, GAIN_ONE, 1'b1}},
    '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1, '{GAIN_ONE, GAIN_ONE, 1'b1}},
    '{24'h800000, 24'h800000, 24'h800000, 1'b1, '{GAIN_ONE, GAIN_ONE, 1'b1}}
  };
  vec_row_t pt_rows[] = '{
    '{24'sd0, 24'sd0, 24'sd0, 1'b0, '{0, 0, 0}},
    '{24'h800000, 24'h800000, 24'h800000, 1'b1, '{0, GAIN_ONE, 1'b0}},
    '{24'h7FFFFF, 24'sd0, 24'sd0, 1'b1, '{0, GAIN_ONE, 1'b0}},
    '{24'sd0, 24'sd40960, 24'sd0, 1'b1, '{0, GAIN_ONE, 1'b1}},
    '{24'sd4096, 24'sd0, 24'sd0, 1'b0, '{0, 0, 0}},
    '{24'sd41, 24'sd0, 24'sd0, 1'b0, '{0, 0, 0}},
    '{24'sd0, 24'sd40959, 24'sd1, 1'b0, '{0, 0, 0}}
  };
  // zero range: only a zero offset counts as in range
  vec_row_t zr_rows[] = '{
    '{24'sd0, 24'sd0, 24'sd0, 1'b1, '{0, GAIN_ONE, 1'b1}},
    '{24'h800000, 24'h800000, 24'h800000, 1'b1, '{0, GAIN_ONE, 1'b0}},
    '{24'h7FFFFF, 24'sd0, 24'sd0, 1'b1, '{0, GAIN_ONE, 1'b0}},
    '{24'sd0, 24'sd40960, 24'sd0, 1'b1, '{0, GAIN_ONE, 1'b0}},
    '{24'sd0, 24'sd0, 24'sd1, 1'b1, '{0, GAIN_ONE, 1'b0}},
    '{24'sd41, 24'sd0, 24'sd0, 1'b0, '{0, 0, 0}}
  };
  vec_row_t spot_rows[] = '{
    '{24'sd0, -24'sd8192, 24'sd0, 1'b0, '{0, 0, 0}},
    '{24'sd0, 24'sd8192, 24'sd0, 1'b0, '{0, 0, 0}},
    '{24'sd1800, -24'sd8192, 24'sd0, 1'b0, '{0, 0, 0}},
    '{24'sd3000, -24'sd8192, 24'sd0, 1'b0, '{0, 0, 0}},
    '{24'sd3900, -24'sd8192, 24'sd0, 1'b0, '{0, 0, 0}},
    '{24'sd0, 24'sd0, 24'sd1, 1'b0, '{0, 0, 0}},
    '{24'sd8192, 24'sd0, 24'sd0, 1'b0, '{0, 0, 0}}
  };

  task automatic run_rows(input vec_row_t rows[]);
    foreach (rows[i])
      send_word(rows[i].ox, rows[i].oy, rows[i].oz, i % 2, rows[i].has_exp, rows[i].exp_res);
    start <= 1'b0;
    drain();
  endtask

  task automatic random_setting(input int k);
    int t;
    longint inr, outr;
    t = $urandom_range(0, 9);
    write_reg(REG_TYPE, t < 1 ? LT_DIR : (t < 3 ? LT_POINT : (t < 4 ? LT_SPARE : LT_SPOT)));
    case ($urandom_range(0, 5))
      0: write_reg(REG_RANGE, 0);
      1: write_reg(REG_RANGE, 23'h7FFFFF);
      2: write_reg(REG_RANGE, $urandom);
      default: write_reg(REG_RANGE, $urandom_range(1, 20 * VEC_ONE));
    endcase
    inr = longint'(int'($urandom_range(0, 65535))) - 32768;
    outr = longint'(int'($urandom_range(0, 65535))) - 32768;
    if ($urandom_range(0, 3) != 0 && inr < outr) begin
      longint s = inr;
      inr = outr;
      outr = s;
    end
    if (k == 1) begin
      inr = 32767;
      outr = -32768;
    end
    write_reg(REG_INNER, inr);
    write_reg(REG_OUTER, outr);
    for (int i = 0; i < 3; i++)
      write_reg(CFG_IDX_W'(REG_DIR_X + i),
                (k == 2) ? 0 : ($urandom_range(0, 3) == 0 ? $urandom
                                : longint'(rnd_comp(0))));
  endtask

  initial begin
    int mode, near_axis;
    lt_type = RST_TYPE;
    lt_range = RST_RANGE;
    lt_inner = RST_INNER;
    lt_outer = RST_OUTER;
    lt_dir = '{RST_DIR_X, RST_DIR_Y, RST_DIR_Z};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults after reset: point light, range 10
    run_rows(pt_rows);
    write_reg(REG_TYPE, LT_DIR);
    run_rows(dir_rows);
    write_reg(REG_TYPE, LT_SPOT);
    run_rows(spot_rows);
    // empty blend band and short direction
    write_reg(REG_INNER, -32768);
    write_reg(REG_OUTER, 32767);
    write_reg(REG_DIR_Y, 0);
    run_rows(spot_rows);
    write_reg(REG_RANGE, 0);
    write_reg(REG_TYPE, LT_SPARE);
    run_rows(zr_rows);

    for (int k = 0; k < N_RANDOM / 50 + 1; k++) begin
      random_setting(k);
      mode = $urandom_range(0, 3);
      @(posedge clk);
      for (int j = 0; j < 50; j++) begin
        near_axis = $urandom_range(0, 3);
        send_word(rnd_comp(near_axis == 0 ? 2 : mode), rnd_comp(mode),
                  near_axis == 1 ? longint'(rnd_comp(3)) : longint'(rnd_comp(mode)),
                  ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14));
        if (j == 25 && k == 3) begin
          start <= 1'b0;
          drain();
        end
      end
      start <= 1'b0;
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d words (%0d spot) across directional, point and spot settings",
             n_words, n_spot);
    $display("%0d results checked, %0d errors", n_results, errors);
    if (errors == 0 && pending_q.size() == 0)
      $display("light_attenuation_unit_core verification clean");
    else
      $display("light_attenuation_unit_core verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/lau_pkg.sv
sv/light_attenuation_unit_core.sv
test/tb_top.sv
